/* rtl/srsh_pkg.sv */
// Package for the sorted record state hash block.
// Holds the request and result types, item codes, the mix constant and the
// command and status structs between controller and datapath. No dependencies.
package srsh_pkg;

    localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c15;

    typedef enum logic [1:0] {
        FUNC_START  = 2'd0,
        FUNC_HEADER = 2'd1,
        FUNC_RECORD = 2'd2,
        FUNC_FINISH = 2'd3
    } t_func;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [63:0] seed_or_word;
        logic [7:0]         rec_kind;
        logic signed [31:0] rec_health;
        logic signed [23:0] rec_pos_x;
        logic signed [23:0] rec_pos_y;
        logic               rec_alive;
    } t_req;

    typedef struct packed {
        logic [63:0] final_hash;
        logic [6:0]  kept_count;
        logic        overflowed;
    } t_rsp;

    // Controller to datapath commands
    typedef struct packed {
        logic       rd_en;      // read store entry at the scan address
        logic       scan_first; // first read of a search pass: clear the best
        logic       commit;     // best key becomes the lower bound
        logic       mix_rec;    // mix one field of the best record
        logic [1:0] field;      // 0 kind, 1 hp, 2 x, 3 y
        logic       mix_cnt;    // mix the count and post the result
    } t_cmd;

    typedef struct packed {
        logic found;            // a key above the lower bound was seen
    } t_stat;

    // One hash-combine step
    function automatic logic [63:0] mix(input logic [63:0] h, input logic [63:0] v);
        mix = h ^ (v + GOLDEN + (h << 6) + (h >> 2));
    endfunction

    // Whole units of a signed 16.8 fixed-point position, truncated toward zero
    function automatic logic [63:0] pos_whole(input logic [23:0] p);
        logic [15:0] q;
        q = p[23:8];
        if (p[23] && (p[7:0] != 8'd0)) begin
            q = q + 16'd1;
        end
        pos_whole = {{48{q[15]}}, q};
    endfunction

endpackage

/* rtl/srsh_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srsh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic                             i_re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/srsh_ctrl.sv */
// Controller for the sorted record state hash: sequences the finish request
// through search passes over the store and the mix steps. Depends on srsh_pkg.
module srsh_ctrl #(
    parameter int MAX_RECORDS = 64,
    parameter int CW = $clog2(MAX_RECORDS + 1),
    parameter int AW = $clog2(MAX_RECORDS > 1 ? MAX_RECORDS : 2)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fin,
    input  logic [CW-1:0]    i_count,
    input  logic [CW-1:0]    i_best_cnt,
    input  srsh_pkg::t_stat  i_stat,
    output srsh_pkg::t_cmd   o_cmd,
    output logic [AW-1:0]    o_raddr,
    output logic             o_idle
);
    import srsh_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_LAST, S_DECIDE, S_MIX, S_CNT
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_copy, n_copy;
    logic [1:0]    r_step, n_step;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_copy  = r_copy;
        n_step  = r_step;
        o_cmd   = '0;
        o_cmd.field = r_step;
        case (r_state)
            S_IDLE: begin
                if (i_fin) begin
                    n_idx   = '0;
                    n_state = (i_count == '0) ? S_CNT : S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.rd_en      = 1'b1;
                o_cmd.scan_first = (r_idx == '0);
                n_idx = r_idx + 1'b1;
                if (r_idx == i_count - 1'b1) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_copy = '0;
                n_step = '0;
                if (i_stat.found) begin
                    o_cmd.commit = 1'b1;
                    n_state = S_MIX;
                end else begin
                    n_state = S_CNT;
                end
            end
            S_MIX: begin
                o_cmd.mix_rec = 1'b1;
                n_step = r_step + 2'd1;
                if (r_step == 2'd3) begin
                    if (r_copy == i_best_cnt - 1'b1) begin
                        n_idx   = '0;
                        n_state = S_SCAN;
                    end else begin
                        n_copy = r_copy + 1'b1;
                    end
                end
            end
            S_CNT: begin
                o_cmd.mix_cnt = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_copy  <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_copy  <= n_copy;
            r_step  <= n_step;
        end
    end

    assign o_raddr = r_idx[AW-1:0];
    assign o_idle  = (r_state == S_IDLE);
endmodule

/* rtl/srsh_dp.sv */
// Datapath for the sorted record state hash: chain hash, record store,
// minimum search registers, mix unit and result register.
// Depends on srsh_pkg and srsh_ram.
module srsh_dp #(
    parameter int MAX_RECORDS = 64,
    parameter int CW = $clog2(MAX_RECORDS + 1),
    parameter int AW = $clog2(MAX_RECORDS > 1 ? MAX_RECORDS : 2)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_acc,
    input  srsh_pkg::t_req   i_req,
    input  srsh_pkg::t_cmd   i_cmd,
    input  logic [AW-1:0]    i_raddr,
    output logic [CW-1:0]    o_count,
    output logic [CW-1:0]    o_best_cnt,
    output srsh_pkg::t_stat  o_stat,
    output logic             o_rsp_valid,
    input  logic             i_rsp_ready,
    output srsh_pkg::t_rsp   o_rsp
);
    import srsh_pkg::*;

    localparam logic [CW-1:0] MAXC = CW'(MAX_RECORDS);

    logic [63:0]   r_hash;
    logic [CW-1:0] r_count;
    logic          r_ovf;
    logic          r_rv;
    logic          r_found;
    logic          r_have_prev;
    logic [87:0]   r_prev;
    logic [CW-1:0] r_best_cnt;
    logic [7:0]    r_b_kind;
    logic [31:0]   r_b_hp;
    logic [23:0]   r_b_x;
    logic [23:0]   r_b_y;
    logic          r_out_valid;
    t_rsp          r_rsp;

    logic          store_we;
    logic [39:0]   kh_rd;
    logic [47:0]   pos_rd;
    logic [87:0]   rd_key, best_key;
    logic          above_prev;
    logic [63:0]   mix_v, mix_out;

    assign store_we = i_acc && (i_req.func == FUNC_RECORD) && i_req.rec_alive &&
                      (r_count < MAXC);

    srsh_ram #(.WIDTH(40), .DEPTH(MAX_RECORDS)) u_kh_ram (
        .i_clk  (i_clk),
        .i_we   (store_we),
        .i_waddr(r_count[AW-1:0]),
        .i_wdata({i_req.rec_kind, i_req.rec_health}),
        .i_re   (i_cmd.rd_en),
        .i_raddr(i_raddr),
        .o_rdata(kh_rd)
    );

    srsh_ram #(.WIDTH(48), .DEPTH(MAX_RECORDS)) u_pos_ram (
        .i_clk  (i_clk),
        .i_we   (store_we),
        .i_waddr(r_count[AW-1:0]),
        .i_wdata({i_req.rec_pos_x, i_req.rec_pos_y}),
        .i_re   (i_cmd.rd_en),
        .i_raddr(i_raddr),
        .o_rdata(pos_rd)
    );

    // Sort keys: flip sign bits so signed fields compare as unsigned
    assign rd_key   = {kh_rd[39:32], ~kh_rd[31], kh_rd[30:0],
                       ~pos_rd[47], pos_rd[46:24], ~pos_rd[23], pos_rd[22:0]};
    assign best_key = {r_b_kind, ~r_b_hp[31], r_b_hp[30:0],
                       ~r_b_x[23], r_b_x[22:0], ~r_b_y[23], r_b_y[22:0]};
    assign above_prev = !r_have_prev || (rd_key > r_prev);

    // Select the word to mix
    always_comb begin
        mix_v = i_req.seed_or_word;
        if (i_cmd.mix_cnt) begin
            mix_v = 64'(r_count);
        end else if (i_cmd.mix_rec) begin
            case (i_cmd.field)
                2'd0:    mix_v = {56'd0, r_b_kind};
                2'd1:    mix_v = {{32{r_b_hp[31]}}, r_b_hp};
                2'd2:    mix_v = pos_whole(r_b_x);
                default: mix_v = pos_whole(r_b_y);
            endcase
        end
    end
    assign mix_out = mix(r_hash, mix_v);

    // Control state: hash, count, flags, search and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash      <= '0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_rv        <= 1'b0;
            r_found     <= 1'b0;
            r_have_prev <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rv <= i_cmd.rd_en;
            if (i_acc) begin
                case (i_req.func)
                    FUNC_START: begin
                        r_hash  <= i_req.seed_or_word;
                        r_count <= '0;
                        r_ovf   <= 1'b0;
                    end
                    FUNC_HEADER: r_hash <= mix_out;
                    FUNC_RECORD: begin
                        if (store_we) begin
                            r_count <= r_count + 1'b1;
                        end else if (i_req.rec_alive) begin
                            r_ovf <= 1'b1;
                        end
                    end
                    default: r_have_prev <= 1'b0;
                endcase
            end
            if (i_cmd.scan_first) begin
                r_found <= 1'b0;
            end
            if (r_rv && above_prev && (!r_found || rd_key < best_key)) begin
                r_found <= 1'b1;
            end
            if (i_cmd.commit) begin
                r_have_prev <= 1'b1;
            end
            if (i_cmd.mix_rec) begin
                r_hash <= mix_out;
            end
            if (i_cmd.mix_cnt) begin
                r_hash      <= mix_out;
                r_count     <= '0;
                r_ovf       <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: best record, lower bound and result
    always_ff @(posedge i_clk) begin
        if (r_rv && above_prev) begin
            if (!r_found || rd_key < best_key) begin
                {r_b_kind, r_b_hp} <= kh_rd;
                {r_b_x, r_b_y}     <= pos_rd;
                r_best_cnt         <= CW'(1);
            end else if (rd_key == best_key) begin
                r_best_cnt <= r_best_cnt + 1'b1;
            end
        end
        if (i_cmd.commit) begin
            r_prev <= best_key;
        end
        if (i_cmd.mix_cnt) begin
            r_rsp.final_hash <= mix_out;
            r_rsp.kept_count <= 7'(r_count);
            r_rsp.overflowed <= r_ovf;
        end
    end

    assign o_count       = r_count;
    assign o_best_cnt    = r_best_cnt;
    assign o_stat.found  = r_found;
    assign o_rsp_valid   = r_out_valid;
    assign o_rsp         = r_rsp;
endmodule

/* rtl/sorted_record_state_hash.sv */
// Top level of the sorted record state hash. Instantiates the controller and
// the datapath. Depends on srsh_pkg, srsh_ctrl, srsh_dp and srsh_ram.
//
// Start, header and record requests are accepted back to back. A finish
// request walks the record store with repeated minimum-search passes, each
// pass reading one store entry per cycle. No request is accepted during that
// walk, and a further finish waits until the result has been taken. Store
// contents need no clearing after reset.
module sorted_record_state_hash #(
    parameter int MAX_RECORDS = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  srsh_pkg::t_req   i_in,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output srsh_pkg::t_rsp   o_out
);
    import srsh_pkg::*;

    localparam int CW = $clog2(MAX_RECORDS + 1);
    localparam int AW = $clog2(MAX_RECORDS > 1 ? MAX_RECORDS : 2);

    t_cmd          cmd;
    t_stat         stat;
    logic [AW-1:0] raddr;
    logic [CW-1:0] count, best_cnt;
    logic          idle, acc, fin;

    // Accept requests while idle; hold a finish while a result waits
    assign o_in_ready = idle && (!o_out_valid || (i_in.func != FUNC_FINISH));
    assign acc = i_in_valid && o_in_ready;
    assign fin = acc && (i_in.func == FUNC_FINISH);

    srsh_ctrl #(.MAX_RECORDS(MAX_RECORDS)) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fin     (fin),
        .i_count   (count),
        .i_best_cnt(best_cnt),
        .i_stat    (stat),
        .o_cmd     (cmd),
        .o_raddr   (raddr),
        .o_idle    (idle)
    );

    srsh_dp #(.MAX_RECORDS(MAX_RECORDS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (acc),
        .i_req      (i_in),
        .i_cmd      (cmd),
        .i_raddr    (raddr),
        .o_count    (count),
        .o_best_cnt (best_cnt),
        .o_stat     (stat),
        .o_rsp_valid(o_out_valid),
        .i_rsp_ready(i_out_ready),
        .o_rsp      (o_out)
    );

`ifndef ASSERT_OFF
    a_busy_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin |=> !idle) else $error("finish did not start the walk");
    a_no_finish_on_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin |-> !o_out_valid) else $error("finish accepted over a pending result");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count <= CW'(MAX_RECORDS)) else $error("stored count beyond capacity");
    a_no_read_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        idle |-> !cmd.rd_en && !cmd.mix_rec) else $error("store walk while idle");
`endif
endmodule

/* sim/tb_top.sv */
// Testbench for sorted_record_state_hash: drives directed and random snapshot requests
// and checks each emitted result against an in-bench predictor. Depends on srsh_pkg.
`timescale 1ns / 1ps

module tb_top;
    import srsh_pkg::*;

    localparam int CAPACITY = 64;
    localparam logic [63:0] MIX_CONST = 64'h9e3779b97f4a7c15;

    logic   i_clk;
    logic   i_rst_n;
    logic   i_in_valid;
    logic   o_in_ready;
    t_req   i_in;
    logic   o_out_valid;
    logic   i_out_ready;
    t_rsp   o_out;

    sorted_record_state_hash #(.MAX_RECORDS(CAPACITY)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out)
    );

    // Predictor state
    typedef struct {
        logic [7:0]         kind;
        logic signed [31:0] hp;
        logic signed [23:0] px;
        logic signed [23:0] py;
    } t_snap_rec;

    logic [63:0] model_hash;
    t_snap_rec   model_recs[CAPACITY];
    int          model_count;
    bit          model_ovf;

    t_req pending_reqs[$];
    t_rsp expected_hashes[$];
    int   mismatches;
    bit   stim_done;
    bit   quiet;
    bit   in_hold;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    function automatic logic [63:0] hash_step(logic [63:0] h, logic [63:0] v);
        return h ^ (v + MIX_CONST + (h << 6) + (h >> 2));
    endfunction

    // Whole units toward zero, sign-extended to 64 bits
    function automatic logic [63:0] whole_units(logic signed [23:0] p);
        int q;
        q = int'(p) / 256;
        return 64'(signed'(longint'(q)));
    endfunction

    function automatic bit rec_less(t_snap_rec a, t_snap_rec b);
        if (a.kind != b.kind) return a.kind < b.kind;
        if (a.hp != b.hp) return a.hp < b.hp;
        if (a.px != b.px) return a.px < b.px;
        return a.py < b.py;
    endfunction

    // Append one request to the pending queue
    task automatic add_req(t_req r);
        pending_reqs = {pending_reqs, r};
    endtask

    // Advance the predictor by one accepted request
    task automatic predict_request(t_req r);
        t_snap_rec work[CAPACITY];
        t_snap_rec key;
        t_rsp rsp;
        logic [63:0] h;
        int j;
        case (t_func'(r.func))
            FUNC_START: begin
                model_hash = r.seed_or_word;
                model_count = 0;
                model_ovf = 0;
            end
            FUNC_HEADER: begin
                model_hash = hash_step(model_hash, r.seed_or_word);
            end
            FUNC_RECORD: begin
                if (r.rec_alive) begin
                    if (model_count >= CAPACITY) begin
                        model_ovf = 1;
                    end else begin
                        model_recs[model_count] = '{r.rec_kind, r.rec_health,
                                                    r.rec_pos_x, r.rec_pos_y};
                        model_count++;
                    end
                end
            end
            default: begin
                for (int i = 0; i < model_count; i++) work[i] = model_recs[i];
                for (int i = 1; i < model_count; i++) begin
                    key = work[i];
                    j = i;
                    while (j > 0 && rec_less(key, work[j-1])) begin
                        work[j] = work[j-1];
                        j--;
                    end
                    work[j] = key;
                end
                h = model_hash;
                for (int i = 0; i < model_count; i++) begin
                    h = hash_step(h, 64'(work[i].kind));
                    h = hash_step(h, 64'(signed'(work[i].hp)));
                    h = hash_step(h, whole_units(work[i].px));
                    h = hash_step(h, whole_units(work[i].py));
                end
                h = hash_step(h, 64'(model_count));
                rsp.final_hash = h;
                rsp.kept_count = 7'(model_count);
                rsp.overflowed = model_ovf;
                expected_hashes = {expected_hashes, rsp};
                model_hash = h;
                model_count = 0;
                model_ovf = 0;
            end
        endcase
    endtask

    function automatic t_req make_req(t_func f);
        t_req r;
        r.func = f;
        r.seed_or_word = {$urandom, $urandom};
        r.rec_kind = 8'($urandom_range(0, 7));
        if ($urandom_range(0, 3) == 0) r.rec_kind = 8'($urandom);
        r.rec_health = 32'($urandom_range(0, 5)) - 32'sd2;
        if ($urandom_range(0, 3) == 0) r.rec_health = $urandom;
        r.rec_pos_x = 24'($urandom);
        r.rec_pos_y = 24'($urandom);
        r.rec_alive = ($urandom_range(0, 9) != 0);
        return r;
    endfunction

    function automatic t_req make_rec(logic [7:0] k, logic [31:0] hp,
                                      logic [23:0] x, logic [23:0] y, bit alive);
        t_req r;
        r = make_req(FUNC_RECORD);
        r.rec_kind = k;
        r.rec_health = hp;
        r.rec_pos_x = x;
        r.rec_pos_y = y;
        r.rec_alive = alive;
        return r;
    endfunction

    // Fill the request queue: directed snapshots, then random ones
    initial begin
        t_req r;
        int nrec;
        // header and record before any start, then a finish with that record stored and one with nothing stored
        r = make_req(FUNC_HEADER); r.seed_or_word = 64'h8000_0000_0000_0000;
        add_req(r);
        add_req(make_rec(8'hFF, 32'h8000_0000, 24'h800000, 24'h7FFFFF, 1));
        add_req(make_req(FUNC_FINISH));
        add_req(make_req(FUNC_FINISH));
        r = make_req(FUNC_START); r.seed_or_word = '1;
        add_req(r);
        r = make_req(FUNC_HEADER); r.seed_or_word = 64'h7FFF_FFFF_FFFF_FFFF;
        add_req(r);
        r = make_req(FUNC_HEADER); r.seed_or_word = -64'sd1;
        add_req(r);
        // extremes, negative fractions, a dead record and equal keys
        add_req(make_rec(8'h00, 32'h7FFF_FFFF, 24'h7FFFFF, 24'h800000, 1));
        add_req(make_rec(8'h00, 32'hFFFF_FFFF, 24'hFFFF01, 24'hFFFF00, 1));
        add_req(make_rec(8'h00, 32'hFFFF_FFFF, 24'hFFFF01, 24'hFFFF00, 1));
        add_req(make_rec(8'h00, 32'hFFFF_FFFF, 24'hFFFF01, 24'hFFFF80, 1));
        add_req(make_rec(8'h55, 32'h0, 24'h0000FF, 24'hFFFFFF, 1));
        add_req(make_rec(8'h01, 32'h0, 24'h0, 24'h0, 0));
        add_req(make_req(FUNC_FINISH));
        // overflow: fill past capacity
        r = make_req(FUNC_START); r.seed_or_word = '0;
        add_req(r);
        for (int i = 0; i < CAPACITY + 3; i++) begin
            r = make_req(FUNC_RECORD); r.rec_alive = 1;
            add_req(r);
        end
        add_req(make_req(FUNC_FINISH));
        // random snapshots, mostly well formed, some noise
        while (pending_reqs.size() < 1800) begin
            if ($urandom_range(0, 9) == 0) begin
                add_req(make_req(t_func'($urandom_range(0, 3))));
                continue;
            end
            if ($urandom_range(0, 5) != 0) add_req(make_req(FUNC_START));
            repeat ($urandom_range(0, 3)) add_req(make_req(FUNC_HEADER));
            nrec = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70)
                                                : $urandom_range(0, 10);
            repeat (nrec) add_req(make_req(FUNC_RECORD));
            add_req(make_req(FUNC_FINISH));
        end
    end

    // Reset and quiet-stretch control
    initial begin
        mismatches = 0;
        stim_done = 0;
        quiet = 0;
        i_rst_n = 1'b0;
        model_hash = '0;
        model_count = 0;
        model_ovf = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
    end

    // Hold a stretch with no idling in the middle of the run
    always @(negedge i_clk) begin
        if (pending_reqs.size() < 1200 && pending_reqs.size() > 900) quiet <= 1'b1;
        else quiet <= 1'b0;
    end

    // Driver: present the next request at the falling edge
    initial begin
        i_in_valid = 1'b0;
        i_in = '0;
        i_out_ready = 1'b0;
        in_hold = 1'b0;
    end

    // Mark a request that was offered but not taken at the rising edge
    always @(posedge i_clk) begin
        in_hold <= i_in_valid && !o_in_ready;
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_hold) begin
                // hold the request until it is taken
            end else if (pending_reqs.size() > 0 &&
                         (quiet || $urandom_range(0, 99) >= 30)) begin
                i_in <= pending_reqs.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
            i_out_ready <= quiet || ($urandom_range(0, 99) >= 30);
        end
    end

    // Monitor: predict on accepted requests, check accepted results
    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) predict_request(i_in);
            if (o_out_valid && i_out_ready) begin
                if (expected_hashes.size() == 0) begin
                    $display("%0t: unexpected result hash=%h count=%0d ovf=%0b", $time,
                             o_out.final_hash, o_out.kept_count, o_out.overflowed);
                    mismatches++;
                end else begin
                    exp_rsp = expected_hashes.pop_front();
                    if (exp_rsp.final_hash !== o_out.final_hash) begin
                        $display("%0t: final_hash expected %h actual %h", $time,
                                 exp_rsp.final_hash, o_out.final_hash);
                        mismatches++;
                    end
                    if (exp_rsp.kept_count !== o_out.kept_count) begin
                        $display("%0t: kept_count expected %0d actual %0d", $time,
                                 exp_rsp.kept_count, o_out.kept_count);
                        mismatches++;
                    end
                    if (exp_rsp.overflowed !== o_out.overflowed) begin
                        $display("%0t: overflowed expected %0b actual %0b", $time,
                                 exp_rsp.overflowed, o_out.overflowed);
                        mismatches++;
                    end
                end
            end
        end
    end

    // End of run: drain, then settle
    initial begin
        @(posedge i_rst_n);
        wait (pending_reqs.size() == 0);
        @(posedge i_clk iff (i_in_valid && o_in_ready));
        @(posedge i_clk);
        wait (expected_hashes.size() == 0);
        repeat (600) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Timeout
    initial begin
        #50ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

/* sorted_record_state_hash.f */
rtl/srsh_pkg.sv
rtl/srsh_ram.sv
rtl/srsh_ctrl.sv
rtl/srsh_dp.sv
rtl/sorted_record_state_hash.sv
sim/tb_top.sv
